/* rtl/gopd_pkg.sv */
// Shared types, codes and helpers for the grid occupancy point decimator.
package gopd_pkg;

    // Operation codes carried with each input beat.
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result field widths fixed by the interface.
    localparam int unsigned COUNT_W   = 20;
    localparam int unsigned CELL_W    = 19;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Occupancy memory word width and the select width inside one word.
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned BIT_SEL_W = 5;

    // Depth of the queue between the address pipeline and the occupancy engine.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_TIME_ORIGIN  = 2'd0,
        REG_VALUE_ORIGIN = 2'd1,
        REG_TIME_SCALE   = 2'd2,
        REG_VALUE_SCALE  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [31:0] time_origin;
        logic [31:0] value_origin;
        logic [31:0] time_scale;
        logic [31:0] value_scale;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_FETCH,
        ST_CHECK
    } t_back_state;

    // Cell index width: enough for every cell, and at least one word address bit.
    function automatic int unsigned gopd_idx_w(input int unsigned cells);
        int unsigned w;
        w = $clog2(cells);
        return (w > BIT_SEL_W) ? w : BIT_SEL_W + 1;
    endfunction

endpackage

/* rtl/gopd_fifo.sv */
// Small register queue between the address pipeline and the occupancy engine.
module gopd_fifo
    import gopd_pkg::*;
#(
    parameter int unsigned WIDTH = 84,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/gopd_front.sv */
// Address pipeline: origin offset, Q16.16 scaling, saturation and cell index.
module gopd_front
    import gopd_pkg::*;
#(
    parameter int unsigned X_CELLS = 4096,
    parameter int unsigned Y_CELLS = 128,
    parameter int unsigned IDX_W   = 19,
    parameter int unsigned ITEM_W  = 84
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_accept,
    input  logic               i_operation,
    input  logic signed [31:0] i_time_in,
    input  logic signed [31:0] i_value_in,
    output logic               o_stall,
    output logic               o_item_valid,
    output logic [ITEM_W-1:0]  o_item,
    input  logic               i_queue_full
);

    localparam int unsigned COL_W = $clog2(X_CELLS);
    localparam int unsigned ROW_W = $clog2(Y_CELLS);

    logic        adv;
    logic [32:0] t_diff, v_diff;
    logic        t_pos, v_pos;
    logic [63:0] t_prod, v_prod;
    logic [31:0] t_whole, v_whole;

    // Stage A: offsets
    logic        r_a_valid, r_a_op;
    logic [31:0] r_a_time, r_a_value, r_a_toff, r_a_voff;
    // Stage B: products
    logic        r_b_valid, r_b_op;
    logic [31:0] r_b_time, r_b_value;
    logic [63:0] r_b_tprod, r_b_vprod;
    // Stage C: saturated coordinates
    logic             r_c_valid, r_c_op;
    logic [31:0]      r_c_time, r_c_value;
    logic [COL_W-1:0] r_c_col;
    logic [ROW_W-1:0] r_c_row;
    // Stage D: cell index
    logic             r_d_valid, r_d_op;
    logic [31:0]      r_d_time, r_d_value;
    logic [IDX_W-1:0] r_d_idx;

    // The whole pipeline moves together; it holds only when its last stage cannot drain.
    assign adv     = !(r_d_valid && i_queue_full);
    assign o_stall = !adv;

    assign t_diff = {i_time_in[31], i_time_in} - {i_cfg.time_origin[31], i_cfg.time_origin};
    assign v_diff = {i_value_in[31], i_value_in} - {i_cfg.value_origin[31], i_cfg.value_origin};
    assign t_pos  = !t_diff[32] && (t_diff != '0);
    assign v_pos  = !v_diff[32] && (v_diff != '0);

    assign t_prod = r_a_toff * i_cfg.time_scale;
    assign v_prod = r_a_voff * i_cfg.value_scale;

    assign t_whole = r_b_tprod[63:32];
    assign v_whole = r_b_vprod[63:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_op    <= i_operation;
            r_a_time  <= i_time_in;
            r_a_value <= i_value_in;
            r_a_toff  <= t_pos ? t_diff[31:0] : '0;
            r_a_voff  <= v_pos ? v_diff[31:0] : '0;

            r_b_op    <= r_a_op;
            r_b_time  <= r_a_time;
            r_b_value <= r_a_value;
            r_b_tprod <= t_prod;
            r_b_vprod <= v_prod;

            r_c_op    <= r_b_op;
            r_c_time  <= r_b_time;
            r_c_value <= r_b_value;
            r_c_col   <= (t_whole > 32'(X_CELLS - 1)) ? COL_W'(X_CELLS - 1)
                                                      : t_whole[COL_W-1:0];
            r_c_row   <= (v_whole > 32'(Y_CELLS - 1)) ? ROW_W'(Y_CELLS - 1)
                                                      : v_whole[ROW_W-1:0];

            r_d_op    <= r_c_op;
            r_d_time  <= r_c_time;
            r_d_value <= r_c_value;
            r_d_idx   <= IDX_W'(IDX_W'(r_c_row) * IDX_W'(X_CELLS)) + IDX_W'(r_c_col);
        end
    end

    assign o_item_valid = r_d_valid;
    assign o_item       = {r_d_op, r_d_time, r_d_value, r_d_idx};

endmodule

/* rtl/gopd_back.sv */
// Occupancy engine: bit memory read-modify-write, kept count, clearing sweep, result register.
module gopd_back
    import gopd_pkg::*;
#(
    parameter int unsigned X_CELLS = 4096,
    parameter int unsigned Y_CELLS = 128,
    parameter int unsigned IDX_W   = 19,
    parameter int unsigned ITEM_W  = 84
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_queue_empty,
    input  logic [ITEM_W-1:0]  i_item,
    output logic               o_queue_pop,
    output logic               o_init_busy,
    input  logic               i_pop,
    output logic               o_out_valid,
    output logic signed [31:0] o_time_out,
    output logic signed [31:0] o_value_out,
    output logic [CELL_W-1:0]  o_cell_index,
    output logic [COUNT_W-1:0] o_kept_total
);

    localparam int unsigned CELL_TOTAL = X_CELLS * Y_CELLS;
    localparam int unsigned WORDS      = (CELL_TOTAL + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WADDR_W    = IDX_W - BIT_SEL_W;

    t_back_state r_state, n_state;

    logic [WORD_BITS-1:0] r_mem [0:WORDS-1];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WADDR_W-1:0]   r_sweep;
    logic                 r_init;
    logic [COUNT_W-1:0]   r_count, count_inc;
    logic [31:0]          r_cur_time, r_cur_value;
    logic [IDX_W-1:0]     r_cur_idx;
    logic                 r_out_valid;

    logic                 item_op;
    logic [31:0]          item_time, item_value;
    logic [IDX_W-1:0]     item_idx;
    logic                 sweep_last, taken, out_free;
    logic                 mem_we, mem_re, out_load, clear_start;
    logic [WADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    assign item_op    = i_item[ITEM_W-1];
    assign item_time  = i_item[ITEM_W-2 -: 32];
    assign item_value = i_item[ITEM_W-34 -: 32];
    assign item_idx   = i_item[IDX_W-1:0];

    assign sweep_last = (r_sweep == WADDR_W'(WORDS - 1));
    assign taken      = r_rdata[r_cur_idx[BIT_SEL_W-1:0]];
    assign out_free   = !r_out_valid || i_pop;
    assign count_inc  = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_queue_pop = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_sweep;
        mem_raddr   = item_idx[IDX_W-1:BIT_SEL_W];
        mem_wdata   = '0;
        out_load    = 1'b0;
        clear_start = 1'b0;
        unique case (r_state)
            ST_SWEEP: begin
                mem_we = 1'b1;
                if (sweep_last) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (!i_queue_empty) begin
                    o_queue_pop = 1'b1;
                    if (item_op == OP_CLEAR) begin
                        clear_start = 1'b1;
                        n_state     = ST_SWEEP;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (taken) begin
                    n_state = ST_FETCH;
                end else if (out_free) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur_idx[IDX_W-1:BIT_SEL_W];
                    mem_wdata = r_rdata | (WORD_BITS'(1) << r_cur_idx[BIT_SEL_W-1:0]);
                    out_load  = 1'b1;
                    n_state   = ST_FETCH;
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= '0;
            r_init      <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (clear_start) begin
                r_sweep <= '0;
                r_count <= '0;
            end else if (r_state == ST_SWEEP) begin
                r_sweep <= sweep_last ? '0 : r_sweep + 1'b1;
                if (sweep_last) begin
                    r_init <= 1'b0;
                end
            end else if (out_load) begin
                r_count <= count_inc;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_queue_pop) begin
            r_cur_time  <= item_time;
            r_cur_value <= item_value;
            r_cur_idx   <= item_idx;
        end
        if (out_load) begin
            o_time_out   <= r_cur_time;
            o_value_out  <= r_cur_value;
            o_cell_index <= CELL_W'(r_cur_idx);
            o_kept_total <= count_inc;
        end
    end

    assign o_init_busy = r_init;
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/grid_occupancy_point_decimator_unit.sv */
// Top level of the grid occupancy point decimator: config registers, pipeline, queue, engine.
//
//   Channel   Direction  Handshake             Beat contents
//   -------   ---------  --------------------  ------------------------------------------
//   input     in         push / full           i_operation, i_time_in, i_value_in
//   result    out        empty / pop           o_time_out, o_value_out, o_cell_index,
//                                              o_kept_total
//   config    in         i_cfg_we (no wait)    i_cfg_addr, i_cfg_data
//
// A point passes the address pipeline stages A to D, then the occupancy engine's fetch and
// check states (one read and then one write of its 32-bit occupancy word), so the engine
// does not take a new point before it is through with the last one.
// A clear beat sweeps one occupancy word per cycle over (X_CELLS*Y_CELLS+31)/32 words,
// 16384 with the default grid. Reset starts the same sweep, and full stays high until it
// is done. Either side may stall freely: a four-beat queue and a result register
// decouple the pipeline, the engine and the consumer.
module grid_occupancy_point_decimator_unit
    import gopd_pkg::*;
#(
    parameter int unsigned X_CELLS = 4096,
    parameter int unsigned Y_CELLS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input queue side
    input  logic               push,
    output logic               full,
    input  logic               i_operation,
    input  logic signed [31:0] i_time_in,
    input  logic signed [31:0] i_value_in,
    // Result queue side
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_time_out,
    output logic signed [31:0] o_value_out,
    output logic [CELL_W-1:0]  o_cell_index,
    output logic [COUNT_W-1:0] o_kept_total,
    // Configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data
);

    localparam int unsigned CELL_TOTAL = X_CELLS * Y_CELLS;
    localparam int unsigned IDX_W      = gopd_idx_w(CELL_TOTAL);
    localparam int unsigned ITEM_W     = 1 + 32 + 32 + IDX_W;

    t_cfg              r_cfg;
    logic              accept;
    logic              front_stall;
    logic              init_busy;
    logic              fifo_push, fifo_full, fifo_pop, fifo_empty;
    logic [ITEM_W-1:0] front_item, fifo_item;
    logic              out_valid;

    // Configuration registers. Software must only write them while the block is idle (the
    // block does not enforce it), so the pipeline may read them live without a shadow copy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_origin  <= '0;
            r_cfg.value_origin <= '0;
            r_cfg.time_scale   <= 32'h0001_0000;
            r_cfg.value_scale  <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_TIME_ORIGIN:  r_cfg.time_origin  <= i_cfg_data;
                REG_VALUE_ORIGIN: r_cfg.value_origin <= i_cfg_data;
                REG_TIME_SCALE:   r_cfg.time_scale   <= i_cfg_data;
                REG_VALUE_SCALE:  r_cfg.value_scale  <= i_cfg_data;
            endcase
        end
    end

    // Input beats are refused while the pipeline is blocked or the memory is still being
    // cleared after reset.
    assign full   = front_stall || init_busy;
    assign accept = push && !full;

    gopd_front #(
        .X_CELLS (X_CELLS),
        .Y_CELLS (Y_CELLS),
        .IDX_W   (IDX_W),
        .ITEM_W  (ITEM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_time_in    (i_time_in),
        .i_value_in   (i_value_in),
        .o_stall      (front_stall),
        .o_item_valid (fifo_push),
        .o_item       (front_item),
        .i_queue_full (fifo_full)
    );

    gopd_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (front_item),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_data  (fifo_item),
        .o_empty (fifo_empty)
    );

    gopd_back #(
        .X_CELLS (X_CELLS),
        .Y_CELLS (Y_CELLS),
        .IDX_W   (IDX_W),
        .ITEM_W  (ITEM_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (fifo_empty),
        .i_item        (fifo_item),
        .o_queue_pop   (fifo_pop),
        .o_init_busy   (init_busy),
        .i_pop         (pop),
        .o_out_valid   (out_valid),
        .o_time_out    (o_time_out),
        .o_value_out   (o_value_out),
        .o_cell_index  (o_cell_index),
        .o_kept_total  (o_kept_total)
    );

    assign empty = !out_valid;

    // The pipeline never hands a beat to a full queue: its last stage holds instead.
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fifo_push && fifo_full) |=> $stable(front_item))
        else $error("pipeline output changed while the queue was full");

    // The engine only draws from the queue when it holds a beat.
    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("engine popped an empty queue");

    // No input is taken while the post-reset clearing sweep runs.
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !accept)
        else $error("input accepted during the reset sweep");

    // A delivered point always counts itself.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kept_total != '0))
        else $error("result shown with a zero kept count");

endmodule

/* verif/gopd_kept_point_checker.sv */
`timescale 1ns / 1ps
// Checker for the grid occupancy point decimator: predicts kept points and compares result beats.
module gopd_kept_point_checker
    import gopd_pkg::*;
#(
    parameter int unsigned X_CELLS = 4096,
    parameter int unsigned Y_CELLS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic               i_operation,
    input  logic signed [31:0] i_time_in,
    input  logic signed [31:0] i_value_in,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic signed [31:0] i_time_out,
    input  logic signed [31:0] i_value_out,
    input  logic [CELL_W-1:0]  i_cell_index,
    input  logic [COUNT_W-1:0] i_kept_total,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        logic [31:0]        time_point;
        logic [31:0]        value_point;
        logic [CELL_W-1:0]  cell_idx;
        logic [COUNT_W-1:0] kept_total;
    } t_kept_point;

    t_cfg               cfg = '{32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000};
    bit                 cell_taken[int unsigned];
    logic [COUNT_W-1:0] kept_so_far = '0;
    t_kept_point        kept_due[$];
    int                 fails = 0;
    int                 checked = 0;

    // Grid coordinate of one axis: offset from the origin, times the Q16.16 scale, integer
    // part of the 32-fraction-bit product, saturated into [0, cells-1].
    function automatic logic [31:0] grid_coord(input logic signed [31:0] pos,
                                               input logic signed [31:0] origin,
                                               input logic [31:0] scale,
                                               input int unsigned cells);
        logic signed [33:0] offset;
        logic [63:0]        product;
        offset = pos - origin;
        if (offset <= 0) return 32'd0;
        product = 64'(offset[31:0]) * 64'(scale);
        if (product[63:32] > cells - 1) return cells - 1;
        return product[63:32];
    endfunction

    function automatic void report(input string what, input t_kept_point exp_pt,
                                   input t_kept_point got_pt);
        if (fails < 10) begin
            $display("%0t: %s", $realtime, what);
            $display("    expected time %h value %h cell %0d total %0d",
                     exp_pt.time_point, exp_pt.value_point, exp_pt.cell_idx, exp_pt.kept_total);
            $display("    actual   time %h value %h cell %0d total %0d",
                     got_pt.time_point, got_pt.value_point, got_pt.cell_idx, got_pt.kept_total);
        end
        fails++;
    endfunction

    always @(posedge i_clk) begin : watch
        t_kept_point seen;
        t_kept_point due;
        logic [31:0] col;
        logic [31:0] row;
        logic [31:0] idx;
        if (!i_rst_n) begin
            cfg = '{32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000};
            cell_taken.delete();
            kept_so_far = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TIME_ORIGIN:  cfg.time_origin  = i_cfg_data;
                    REG_VALUE_ORIGIN: cfg.value_origin = i_cfg_data;
                    REG_TIME_SCALE:   cfg.time_scale   = i_cfg_data;
                    REG_VALUE_SCALE:  cfg.value_scale  = i_cfg_data;
                    default: ;
                endcase
            end
            // Results first, so a point accepted on this edge never matches a result beat.
            if (i_pop && !i_empty) begin
                seen = '{i_time_out, i_value_out, i_cell_index, i_kept_total};
                if (kept_due.size() == 0) begin
                    report("result beat with no kept point outstanding", '0, seen);
                end else begin
                    due = kept_due.pop_front();
                    checked++;
                    if (seen.time_point !== due.time_point ||
                        seen.value_point !== due.value_point ||
                        seen.cell_idx !== due.cell_idx ||
                        seen.kept_total !== due.kept_total)
                        report("result beat mismatch", due, seen);
                end
            end
            if (i_push && !i_full) begin
                if (i_operation == OP_CLEAR) begin
                    cell_taken.delete();
                    kept_so_far = '0;
                end else begin
                    col = grid_coord(i_time_in, cfg.time_origin, cfg.time_scale, X_CELLS);
                    row = grid_coord(i_value_in, cfg.value_origin, cfg.value_scale, Y_CELLS);
                    idx = row * X_CELLS + col;
                    if (idx < X_CELLS * Y_CELLS && !cell_taken.exists(idx)) begin
                        cell_taken[idx] = 1'b1;
                        if (kept_so_far != COUNT_MAX) kept_so_far++;
                        due = '{i_time_in, i_value_in, idx[CELL_W-1:0], kept_so_far};
                        kept_due = {kept_due, due};
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= kept_due.size();
        o_checked    <= checked;
    end

endmodule

/* verif/grid_occupancy_point_decimator_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the grid occupancy point decimator: stimulus, register writes and verdict.
module grid_occupancy_point_decimator_unit_tb;
    import gopd_pkg::*;

    localparam int unsigned X_CELLS = 4096;
    localparam int unsigned Y_CELLS = 128;
    // A clear, and the pass after reset, walk one occupancy word per cycle.
    localparam int unsigned SWEEP_CYCLES = (X_CELLS * Y_CELLS + 31) / 32;
    // Address pipeline plus engine is well under this; it covers points that keep nothing.
    localparam int unsigned SETTLE_CYCLES = 64;
    // Longest quiet stretch in a correct run is one sweep plus its settle wait; allow
    // several times that before calling the run hung.
    localparam int unsigned STALL_LIMIT = 4 * SWEEP_CYCLES + 20000;
    localparam int unsigned BEATS_PER_SETTING = 160;
    localparam int unsigned SETTINGS_PER_MODE = 3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               i_operation = OP_POINT;
    logic signed [31:0] i_time_in = '0;
    logic signed [31:0] i_value_in = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] o_time_out;
    logic signed [31:0] o_value_out;
    logic [CELL_W-1:0]  o_cell_index;
    logic [COUNT_W-1:0] o_kept_total;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_addr = '0;
    logic [31:0]        i_cfg_data = '0;

    int                 fail_count;
    int                 pending;
    int                 checked;

    // Percentages of cycles in which each side holds back.
    int unsigned        send_idle_pct = 37;
    int unsigned        recv_idle_pct = 53;

    t_cfg               cur_cfg;
    logic [31:0]        past_time[$];
    logic [31:0]        past_value[$];
    bit                 clear_in_flight = 1'b0;
    int                 beats_sent = 0;
    int                 clears_sent = 0;
    int                 configs_applied = 0;
    int unsigned        quiet_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    grid_occupancy_point_decimator_unit #(
        .X_CELLS (X_CELLS),
        .Y_CELLS (Y_CELLS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_time_in    (i_time_in),
        .i_value_in   (i_value_in),
        .empty        (empty),
        .pop          (pop),
        .o_time_out   (o_time_out),
        .o_value_out  (o_value_out),
        .o_cell_index (o_cell_index),
        .o_kept_total (o_kept_total),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    gopd_kept_point_checker #(
        .X_CELLS (X_CELLS),
        .Y_CELLS (Y_CELLS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_operation  (i_operation),
        .i_time_in    (i_time_in),
        .i_value_in   (i_value_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_time_out   (o_time_out),
        .i_value_out  (o_value_out),
        .i_cell_index (o_cell_index),
        .i_kept_total (o_kept_total),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // The result side pops at random; a stalled pop leaves the beat waiting on the ports.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any accepted beat on either side proves the block is still moving.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat accepted for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Offers one input beat, with random idle cycles in front of it, and returns on the
    // edge at which the block takes it. Each call starts and ends on a rising edge.
    task automatic send_beat(input logic op, input logic [31:0] t_q, input logic [31:0] v_q);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_operation <= op;
        i_time_in   <= t_q;
        i_value_in  <= v_q;
        do begin
            @(posedge i_clk);
        end while (full);
        beats_sent++;
        if (op == OP_CLEAR) begin
            clears_sent++;
            clear_in_flight = 1'b1;
        end
    endtask

    task automatic write_reg(input t_cfg_reg which, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= which;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle, so order against beats is moot.
    task automatic apply_config(input t_cfg setting);
        write_reg(REG_TIME_ORIGIN, setting.time_origin);
        write_reg(REG_VALUE_ORIGIN, setting.value_origin);
        write_reg(REG_TIME_SCALE, setting.time_scale);
        write_reg(REG_VALUE_SCALE, setting.value_scale);
        i_cfg_we <= 1'b0;
        cur_cfg = setting;
        configs_applied++;
    endtask

    // Holds the sender back until every kept point has come out, then lets the tail of the
    // pipeline drain. Points that keep nothing leave no trace on the result side, and a
    // clear may still be sweeping the grid, so the wait covers a whole sweep after one.
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (clear_in_flight ? SWEEP_CYCLES + SETTLE_CYCLES : SETTLE_CYCLES)
            @(posedge i_clk);
        clear_in_flight = 1'b0;
    endtask

    // Coordinate for one axis. Most land inside the grid span for the current scale, some
    // fall below the origin, and a few are fully random so every bit toggles.
    function automatic logic [31:0] pick_coord(input logic [31:0] origin,
                                               input logic [31:0] scale,
                                               input int unsigned cells);
        logic [63:0] reach;
        logic [31:0] span;
        if (scale == 0) reach = 64'hFFFF_FFFF;
        else reach = ((64'(cells) + 1) << 32) / scale;
        span = (reach > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : reach[31:0];
        case ($urandom_range(9))
            0: return $urandom;
            1: return origin - $urandom_range(span >> 4);
            default: return origin + $urandom_range(span);
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(7))
            0: return 32'h0001_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0000;
            3: return $urandom;
            4: return $urandom_range(32'h0000_1000, 32'h0000_0010);
            default: return $urandom_range(32'h0008_0000, 32'h0000_0100);
        endcase
    endfunction

    function automatic logic [31:0] pick_origin();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    // One random beat: a rare clear, a revisit of an earlier point (which usually finds
    // its cell taken), or a fresh point.
    task automatic send_random_beat();
        logic [31:0] t_q;
        logic [31:0] v_q;
        int unsigned k;
        if ($urandom_range(299) == 0) begin
            send_beat(OP_CLEAR, $urandom, $urandom);
        end else begin
            if (past_time.size() != 0 && $urandom_range(3) == 0) begin
                k   = $urandom_range(past_time.size() - 1);
                t_q = past_time[k];
                v_q = past_value[k];
            end else begin
                t_q = pick_coord(cur_cfg.time_origin, cur_cfg.time_scale, X_CELLS);
                v_q = pick_coord(cur_cfg.value_origin, cur_cfg.value_scale, Y_CELLS);
                past_time  = {past_time, t_q};
                past_value = {past_value, v_q};
                if (past_time.size() > 200) begin
                    void'(past_time.pop_front());
                    void'(past_value.pop_front());
                end
            end
            send_beat(OP_POINT, t_q, v_q);
        end
    endtask

    initial begin : stimulus
        int unsigned mode;
        int unsigned n;
        int unsigned b;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Reset starts a sweep of the occupancy grid; full stays high until it is done.
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);

        // Unit scales and zero origins: the integer part of each coordinate is the cell.
        apply_config('{time_origin: 32'h0, value_origin: 32'h0,
                       time_scale: 32'h0001_0000, value_scale: 32'h0001_0000});
        send_beat(OP_POINT, 32'h0000_0000, 32'h0000_0000);  // first point of the set, cell 0
        send_beat(OP_POINT, 32'h0000_0000, 32'h0000_0000);  // same cell again, dropped
        send_beat(OP_POINT, 32'hFFFF_0000, 32'h8000_0000);  // below origin, clamps to cell 0
        send_beat(OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);  // both axes saturate high
        send_beat(OP_POINT, 32'h8000_0000, 32'h7FFF_FFFF);  // low column, top row
        send_beat(OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000);  // last column, row 0
        send_beat(OP_POINT, 32'h0000_FFFF, 32'h0001_0000);  // fraction truncates to column 0
        send_beat(OP_POINT, 32'h0001_0000, 32'h0000_0000);  // column 1
        send_beat(OP_POINT, 32'h0FFF_0000, 32'h007F_0000);  // exact last cell, already taken
        send_beat(OP_POINT, 32'h1000_0000, 32'h0005_0000);  // one past the grid, saturates
        send_beat(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // payload ignored on a clear
        send_beat(OP_POINT, 32'h0000_0000, 32'h0000_0000);  // kept again, count restarts
        settle();

        // Zero scales: every point maps to cell 0 whatever the origins.
        apply_config('{time_origin: 32'h7FFF_FFFF, value_origin: 32'h8000_0000,
                       time_scale: 32'h0, value_scale: 32'h0});
        send_beat(OP_CLEAR, 32'h0, 32'h0);
        send_beat(OP_POINT, $urandom, $urandom);
        send_beat(OP_POINT, $urandom, $urandom);
        settle();

        // Largest scales from the lowest origin: offset zero, then small offsets that reach
        // past cell 0 on both axes, then full saturation.
        apply_config('{time_origin: 32'h8000_0000, value_origin: 32'h8000_0000,
                       time_scale: 32'hFFFF_FFFF, value_scale: 32'hFFFF_FFFF});
        send_beat(OP_POINT, 32'h8000_0000, 32'h8000_0000);
        send_beat(OP_POINT, 32'h8000_0002, 32'h8000_0003);
        send_beat(OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        settle();

        // Random part: three idling patterns, each under a few register settings.
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 37;
                    recv_idle_pct = 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 37;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < SETTINGS_PER_MODE; n++) begin
                apply_config('{time_origin: pick_origin(), value_origin: pick_origin(),
                               time_scale: pick_scale(), value_scale: pick_scale()});
                past_time.delete();
                past_value.delete();
                for (b = 0; b < BEATS_PER_SETTING; b++) send_random_beat();
                settle();
            end
        end

        $display("covered %0d input beats, %0d of them grid clears, under %0d register settings",
                 beats_sent, clears_sent, configs_applied);
        $display("checked %0d kept points over three idle patterns", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
